// ===== rtl/pcsc_pkg.sv =====
package pcsc_pkg;

   // Line and pair geometry
   localparam int LINES      = 7;
   localparam int PAIRS      = LINES * (LINES - 1) / 2;
   localparam int DRIVE_BITS = 3;
   localparam int SCAN_BITS  = 20;
   localparam int COUNTER_BITS_DEFAULT = 32;

   localparam logic [DRIVE_BITS-1:0] IDLE_LINE  = DRIVE_BITS'(LINES - 1);
   localparam logic [DRIVE_BITS-1:0] LAST_DRIVE = DRIVE_BITS'(LINES - 2);

   // Opcodes
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_START_REF = 2'd1;
   localparam logic [1:0] OP_START_TST = 2'd2;
   localparam logic [1:0] OP_READ      = 2'd3;

   // Run phases
   localparam logic [1:0] PHASE_IDLE      = 2'd0;
   localparam logic [1:0] PHASE_REFERENCE = 2'd1;
   localparam logic [1:0] PHASE_WARMUP    = 2'd2;
   localparam logic [1:0] PHASE_MEASURE   = 2'd3;

   // Statistic indexes
   localparam logic [5:0] STAT_REF_MAP         = 6'd0;
   localparam logic [5:0] STAT_DISAGREE        = 6'd1;
   localparam logic [5:0] STAT_FIRST_DIS_SCAN  = 6'd2;
   localparam logic [5:0] STAT_FIRST_DIS_MAP   = 6'd3;
   localparam logic [5:0] STAT_MEASURED        = 6'd4;
   localparam logic [5:0] STAT_INCORRECT       = 6'd5;
   localparam logic [5:0] STAT_FP_SCANS        = 6'd6;
   localparam logic [5:0] STAT_FN_SCANS        = 6'd7;
   localparam logic [5:0] STAT_FIRST_ERR_SCAN  = 6'd8;
   localparam logic [5:0] STAT_FIRST_ERR_MAP   = 6'd9;
   localparam logic [5:0] STAT_ELAPSED         = 6'd10;
   localparam logic [5:0] STAT_SCANS_IN_RUN    = 6'd11;
   localparam logic [5:0] STAT_FP_BASE         = 6'd12;
   localparam logic [5:0] STAT_FN_BASE         = 6'(12 + PAIRS);
   localparam logic [5:0] STAT_END             = 6'(12 + 2 * PAIRS);

   // Summary counter slots
   localparam int SUM_SCANS     = 0;
   localparam int SUM_INCORRECT = 1;
   localparam int SUM_FP        = 2;
   localparam int SUM_FN        = 3;
   localparam int SUM_ELAPSED   = 4;
   localparam int SUM_COUNT     = 5;

   // Register indexes
   localparam logic [2:0] REG_REF_SETTLE  = 3'd0;
   localparam logic [2:0] REG_TST_SETTLE  = 3'd1;
   localparam logic [2:0] REG_REF_SCANS   = 3'd2;
   localparam logic [2:0] REG_TST_SCANS   = 3'd3;
   localparam logic [2:0] REG_WARMUP      = 3'd4;

   localparam logic [15:0] REF_SETTLE_RESET = 16'd1000;
   localparam logic [15:0] TST_SETTLE_RESET = 16'd0;
   localparam logic [15:0] REF_SCANS_RESET  = 16'd1000;
   localparam logic [19:0] TST_SCANS_RESET  = 20'd10000;
   localparam logic [7:0]  WARMUP_RESET     = 8'd100;

   typedef struct packed {
      logic [15:0] reference_settle;
      logic [15:0] test_settle;
      logic [15:0] ref_scan_total;
      logic [19:0] test_scans;
      logic [7:0]  warmup_scans;
   } cfg_type;

   typedef struct packed {
      logic                 test_clear;
      logic                 elapsed;
      logic                 scan_measured;
      logic [PAIRS-1:0]     scan_map;
      logic [PAIRS-1:0]     reference_map;
      logic [SCAN_BITS-1:0] scan_number;
   } scan_event_type;

   typedef struct packed {
      logic [DRIVE_BITS-1:0] drive_line;
      logic                  scan_done;
      logic [PAIRS-1:0]      scan_map;
      logic [1:0]            run_state;
      logic                  reference_valid;
      logic                  start_refused;
   } status_type;

   // Driven line of pair k, pairs numbered drive by drive
   function automatic logic [DRIVE_BITS-1:0] pair_drive(input int k);
      int n;
      logic [DRIVE_BITS-1:0] r;
      n = 0;
      r = '0;
      for (int d = 0; d < LINES - 1; d++) begin
         for (int s = d + 1; s < LINES; s++) begin
            if (n == k) r = DRIVE_BITS'(d);
            n++;
         end
      end
      return r;
   endfunction

   // Sensed line of pair k
   function automatic logic [DRIVE_BITS-1:0] pair_sense(input int k);
      int n;
      logic [DRIVE_BITS-1:0] r;
      n = 0;
      r = '0;
      for (int d = 0; d < LINES - 1; d++) begin
         for (int s = d + 1; s < LINES; s++) begin
            if (n == k) r = DRIVE_BITS'(s);
            n++;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/pcsc_scan.sv =====
module pcsc_scan #(
   parameter int COUNTER_BITS = pcsc_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              process,
   input  logic [1:0]                        opcode,
   input  logic [pcsc_pkg::LINES-1:0]        line_levels,
   input  logic [5:0]                        stat_index,
   input  pcsc_pkg::cfg_type                 cfg,
   output pcsc_pkg::status_type              status,
   output pcsc_pkg::scan_event_type          scan_event,
   output logic [31:0]                       read_value
);

   localparam int PAIRS = pcsc_pkg::PAIRS;
   localparam int SB    = pcsc_pkg::SCAN_BITS;

   logic [1:0]                          phase_ff, phase_in;
   logic [pcsc_pkg::DRIVE_BITS-1:0]     drive_ff, drive_in;
   logic [15:0]                         settle_ff, settle_in;
   logic [PAIRS-1:0]                    partial_ff, partial_in;
   logic [SB-1:0]                       scans_ff, scans_in;
   logic [PAIRS-1:0]                    ref_map_ff, ref_map_in;
   logic                                ref_ok_ff, ref_ok_in;
   logic [COUNTER_BITS-1:0]             disagree_ff, disagree_in;
   logic [COUNTER_BITS-1:0]             first_dis_scan_ff, first_dis_scan_in;
   logic [PAIRS-1:0]                    first_dis_map_ff, first_dis_map_in;

   logic [PAIRS-1:0]                    sample_map;
   logic [15:0]                         reload_value;
   logic [SB-1:0]                       scans_inc;
   logic [SB:0]                         scans_plus_wide;
   logic [15:0]                         ref_target;
   logic [SB-1:0]                       test_target;
   logic                                done;
   logic [PAIRS-1:0]                    done_map;
   logic                                refused;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   // Merge the levels of every line above the driven one into the pair map
   always_comb begin
      for (int k = 0; k < PAIRS; k++) begin
         sample_map[k] = partial_ff[k] |
                         ((drive_ff == pcsc_pkg::pair_drive(k)) &&
                          !line_levels[pcsc_pkg::pair_sense(k)]);
      end
   end

   assign reload_value    = (phase_ff == pcsc_pkg::PHASE_REFERENCE) ? cfg.reference_settle
                                                                    : cfg.test_settle;
   assign scans_inc       = scans_ff + 1'b1;
   assign scans_plus_wide = {1'b0, scans_ff} + 1'b1;
   assign ref_target      = (cfg.ref_scan_total == '0) ? 16'd1 : cfg.ref_scan_total;
   assign test_target     = (cfg.test_scans == '0) ? SB'(1) : cfg.test_scans;

   always_comb begin
      phase_in          = phase_ff;
      drive_in          = drive_ff;
      settle_in         = settle_ff;
      partial_in        = partial_ff;
      scans_in          = scans_ff;
      ref_map_in        = ref_map_ff;
      ref_ok_in         = ref_ok_ff;
      disagree_in       = disagree_ff;
      first_dis_scan_in = first_dis_scan_ff;
      first_dis_map_in  = first_dis_map_ff;
      done              = 1'b0;
      done_map          = '0;
      refused           = 1'b0;
      scan_event.test_clear    = 1'b0;
      scan_event.elapsed       = 1'b0;
      scan_event.scan_measured = 1'b0;
      scan_event.scan_map      = sample_map;
      scan_event.reference_map = ref_map_ff;
      scan_event.scan_number   = scans_inc;

      if (process) begin
         unique case (opcode)
            pcsc_pkg::OP_TICK: begin
               if (phase_ff != pcsc_pkg::PHASE_IDLE) begin
                  scan_event.elapsed = (phase_ff == pcsc_pkg::PHASE_MEASURE);
                  if (settle_ff != '0) begin
                     settle_in = settle_ff - 1'b1;
                  end else begin
                     settle_in = reload_value;
                     if (drive_ff == pcsc_pkg::LAST_DRIVE) begin
                        done       = 1'b1;
                        done_map   = sample_map;
                        partial_in = '0;
                        drive_in   = '0;
                        scans_in   = scans_inc;
                        unique case (phase_ff)
                           pcsc_pkg::PHASE_REFERENCE: begin
                              if (scans_ff == '0) begin
                                 ref_map_in = sample_map;
                              end else if (sample_map != ref_map_ff) begin
                                 disagree_in = sat_inc(disagree_ff);
                                 if (first_dis_scan_ff == '0) begin
                                    first_dis_scan_in = COUNTER_BITS'(scans_plus_wide);
                                    first_dis_map_in  = sample_map;
                                 end
                              end
                              if (scans_inc >= SB'(ref_target)) begin
                                 ref_ok_in = (disagree_in == '0);
                                 phase_in  = pcsc_pkg::PHASE_IDLE;
                              end
                           end
                           pcsc_pkg::PHASE_WARMUP: begin
                              if (scans_inc >= SB'(cfg.warmup_scans)) begin
                                 phase_in = pcsc_pkg::PHASE_MEASURE;
                                 scans_in = '0;
                              end
                           end
                           pcsc_pkg::PHASE_MEASURE: begin
                              scan_event.scan_measured = 1'b1;
                              if (scans_inc >= test_target) phase_in = pcsc_pkg::PHASE_IDLE;
                           end
                           default: ;
                        endcase
                     end else begin
                        partial_in = sample_map;
                        drive_in   = drive_ff + 1'b1;
                     end
                  end
               end
            end
            pcsc_pkg::OP_START_REF: begin
               if (phase_ff != pcsc_pkg::PHASE_IDLE) begin
                  refused = 1'b1;
               end else begin
                  ref_ok_in         = 1'b0;
                  disagree_in       = '0;
                  first_dis_scan_in = '0;
                  first_dis_map_in  = '0;
                  phase_in          = pcsc_pkg::PHASE_REFERENCE;
                  drive_in          = '0;
                  partial_in        = '0;
                  scans_in          = '0;
                  settle_in         = cfg.reference_settle;
               end
            end
            pcsc_pkg::OP_START_TST: begin
               if (phase_ff != pcsc_pkg::PHASE_IDLE || !ref_ok_ff) begin
                  refused = 1'b1;
               end else begin
                  scan_event.test_clear = 1'b1;
                  phase_in   = (cfg.warmup_scans != '0) ? pcsc_pkg::PHASE_WARMUP
                                                        : pcsc_pkg::PHASE_MEASURE;
                  drive_in   = '0;
                  partial_in = '0;
                  scans_in   = '0;
                  settle_in  = cfg.test_settle;
               end
            end
            pcsc_pkg::OP_READ: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      status.drive_line      = (phase_in == pcsc_pkg::PHASE_IDLE) ? pcsc_pkg::IDLE_LINE
                                                                  : drive_in;
      status.scan_done       = done;
      status.scan_map        = done_map;
      status.run_state       = phase_in;
      status.reference_valid = ref_ok_in;
      status.start_refused   = refused;
   end

   always_comb begin
      unique case (stat_index)
         pcsc_pkg::STAT_REF_MAP:        read_value = 32'(ref_map_ff);
         pcsc_pkg::STAT_DISAGREE:       read_value = 32'(disagree_ff);
         pcsc_pkg::STAT_FIRST_DIS_SCAN: read_value = 32'(first_dis_scan_ff);
         pcsc_pkg::STAT_FIRST_DIS_MAP:  read_value = 32'(first_dis_map_ff);
         pcsc_pkg::STAT_SCANS_IN_RUN:   read_value = 32'(scans_ff);
         default:                       read_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= pcsc_pkg::PHASE_IDLE;
         drive_ff          <= '0;
         settle_ff         <= '0;
         partial_ff        <= '0;
         scans_ff          <= '0;
         ref_map_ff        <= '0;
         ref_ok_ff         <= 1'b0;
         disagree_ff       <= '0;
         first_dis_scan_ff <= '0;
         first_dis_map_ff  <= '0;
      end else begin
         phase_ff          <= phase_in;
         drive_ff          <= drive_in;
         settle_ff         <= settle_in;
         partial_ff        <= partial_in;
         scans_ff          <= scans_in;
         ref_map_ff        <= ref_map_in;
         ref_ok_ff         <= ref_ok_in;
         disagree_ff       <= disagree_in;
         first_dis_scan_ff <= first_dis_scan_in;
         first_dis_map_ff  <= first_dis_map_in;
      end
   end

endmodule

// ===== rtl/pcsc_stats.sv =====
module pcsc_stats #(
   parameter int COUNTER_BITS = pcsc_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pcsc_pkg::scan_event_type scan_event,
   input  logic [5:0]               stat_index,
   output logic [31:0]              read_value
);

   localparam int PAIRS = pcsc_pkg::PAIRS;
   localparam int SB    = pcsc_pkg::SCAN_BITS;
   localparam int NSUM  = pcsc_pkg::SUM_COUNT;

   logic [COUNTER_BITS-1:0] summary_ff [NSUM];
   logic [COUNTER_BITS-1:0] summary_in [NSUM];
   logic [COUNTER_BITS-1:0] fp_ff [PAIRS];
   logic [COUNTER_BITS-1:0] fp_in [PAIRS];
   logic [COUNTER_BITS-1:0] fn_ff [PAIRS];
   logic [COUNTER_BITS-1:0] fn_in [PAIRS];
   logic [SB-1:0]           first_err_scan_ff, first_err_scan_in;
   logic [PAIRS-1:0]        first_err_map_ff, first_err_map_in;

   logic [PAIRS-1:0]        fp_bits;
   logic [PAIRS-1:0]        fn_bits;
   logic                    mismatch;
   logic [4:0]              fp_sel;
   logic [4:0]              fn_sel;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   assign fp_bits  = scan_event.scan_map & ~scan_event.reference_map;
   assign fn_bits  = scan_event.reference_map & ~scan_event.scan_map;
   assign mismatch = (scan_event.scan_map != scan_event.reference_map);

   always_comb begin
      summary_in        = summary_ff;
      fp_in             = fp_ff;
      fn_in             = fn_ff;
      first_err_scan_in = first_err_scan_ff;
      first_err_map_in  = first_err_map_ff;
      if (scan_event.test_clear) begin
         for (int i = 0; i < NSUM; i++) summary_in[i] = '0;
         for (int k = 0; k < PAIRS; k++) begin
            fp_in[k] = '0;
            fn_in[k] = '0;
         end
         first_err_scan_in = '0;
         first_err_map_in  = '0;
      end else begin
         if (scan_event.elapsed) begin
            summary_in[pcsc_pkg::SUM_ELAPSED] = sat_inc(summary_ff[pcsc_pkg::SUM_ELAPSED]);
         end
         if (scan_event.scan_measured) begin
            summary_in[pcsc_pkg::SUM_SCANS] = sat_inc(summary_ff[pcsc_pkg::SUM_SCANS]);
            if (mismatch) begin
               summary_in[pcsc_pkg::SUM_INCORRECT] =
                  sat_inc(summary_ff[pcsc_pkg::SUM_INCORRECT]);
               if (first_err_scan_ff == '0) begin
                  first_err_scan_in = scan_event.scan_number;
                  first_err_map_in  = scan_event.scan_map;
               end
               if (fp_bits != '0) begin
                  summary_in[pcsc_pkg::SUM_FP] = sat_inc(summary_ff[pcsc_pkg::SUM_FP]);
               end
               if (fn_bits != '0) begin
                  summary_in[pcsc_pkg::SUM_FN] = sat_inc(summary_ff[pcsc_pkg::SUM_FN]);
               end
               for (int k = 0; k < PAIRS; k++) begin
                  if (fp_bits[k]) fp_in[k] = sat_inc(fp_ff[k]);
                  if (fn_bits[k]) fn_in[k] = sat_inc(fn_ff[k]);
               end
            end
         end
      end
   end

   assign fp_sel = 5'(stat_index - pcsc_pkg::STAT_FP_BASE);
   assign fn_sel = 5'(stat_index - pcsc_pkg::STAT_FN_BASE);

   always_comb begin
      read_value = '0;
      unique case (stat_index)
         pcsc_pkg::STAT_MEASURED:
            read_value = 32'(summary_ff[pcsc_pkg::SUM_SCANS]);
         pcsc_pkg::STAT_INCORRECT:
            read_value = 32'(summary_ff[pcsc_pkg::SUM_INCORRECT]);
         pcsc_pkg::STAT_FP_SCANS:
            read_value = 32'(summary_ff[pcsc_pkg::SUM_FP]);
         pcsc_pkg::STAT_FN_SCANS:
            read_value = 32'(summary_ff[pcsc_pkg::SUM_FN]);
         pcsc_pkg::STAT_FIRST_ERR_SCAN:
            read_value = 32'(first_err_scan_ff);
         pcsc_pkg::STAT_FIRST_ERR_MAP:
            read_value = 32'(first_err_map_ff);
         pcsc_pkg::STAT_ELAPSED:
            read_value = 32'(summary_ff[pcsc_pkg::SUM_ELAPSED]);
         default: begin
            if (stat_index >= pcsc_pkg::STAT_FP_BASE && stat_index < pcsc_pkg::STAT_FN_BASE) begin
               read_value = 32'(fp_ff[fp_sel]);
            end else if (stat_index >= pcsc_pkg::STAT_FN_BASE &&
                         stat_index < pcsc_pkg::STAT_END) begin
               read_value = 32'(fn_ff[fn_sel]);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSUM; i++) summary_ff[i] <= '0;
         for (int k = 0; k < PAIRS; k++) begin
            fp_ff[k] <= '0;
            fn_ff[k] <= '0;
         end
         first_err_scan_ff <= '0;
         first_err_map_ff  <= '0;
      end else begin
         summary_ff        <= summary_in;
         fp_ff             <= fp_in;
         fn_ff             <= fn_in;
         first_err_scan_ff <= first_err_scan_in;
         first_err_map_ff  <= first_err_map_in;
      end
   end

endmodule

// ===== rtl/pairwise_continuity_scan_checker_top.sv =====
// Pipeline: an accepted transaction waits in the input register, its result in the
// output register. Throughput: one transaction per cycle unless rsp_tready stalls.
// The scan, compare and counter updates all complete in the single step from input
// register to output register.
// Reset (synchronous, active high) returns to idle, clears the reference, every
// statistic and both handshake stages, and loads the register defaults.
module pairwise_continuity_scan_checker_top #(
   parameter int COUNTER_BITS = pcsc_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // line_levels[6:0], stat_index[12:7], zero above
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // drive_line[2:0], scan_done[3], scan_map[24:4],
                                    // run_state[26:25], reference_valid[27],
                                    // start_refused[28], read_value[60:29], zero above
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LINES = pcsc_pkg::LINES;

   pcsc_pkg::cfg_type        cfg_ff, cfg_in;

   logic                     in_valid_ff, in_valid_in;
   logic [1:0]               in_opcode_ff;
   logic [LINES-1:0]         in_levels_ff;
   logic [5:0]               in_index_ff;

   logic                     out_valid_ff, out_valid_in;
   pcsc_pkg::status_type     out_status_ff;
   logic [31:0]              out_read_ff;

   logic                     req_accept;
   logic                     advance;
   pcsc_pkg::status_type     status;
   pcsc_pkg::scan_event_type scan_event;
   logic [31:0]              scan_read;
   logic [31:0]              stats_read;
   logic [31:0]              read_value;
   logic                     cfg_write;

   // Configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (csr_paddr[4:2])
            pcsc_pkg::REG_REF_SETTLE: cfg_in.reference_settle = csr_pwdata[15:0];
            pcsc_pkg::REG_TST_SETTLE: cfg_in.test_settle      = csr_pwdata[15:0];
            pcsc_pkg::REG_REF_SCANS:  cfg_in.ref_scan_total   = csr_pwdata[15:0];
            pcsc_pkg::REG_TST_SCANS:  cfg_in.test_scans       = csr_pwdata[19:0];
            pcsc_pkg::REG_WARMUP:     cfg_in.warmup_scans     = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         pcsc_pkg::REG_REF_SETTLE: csr_prdata = 32'(cfg_ff.reference_settle);
         pcsc_pkg::REG_TST_SETTLE: csr_prdata = 32'(cfg_ff.test_settle);
         pcsc_pkg::REG_REF_SCANS:  csr_prdata = 32'(cfg_ff.ref_scan_total);
         pcsc_pkg::REG_TST_SCANS:  csr_prdata = 32'(cfg_ff.test_scans);
         pcsc_pkg::REG_WARMUP:     csr_prdata = 32'(cfg_ff.warmup_scans);
         default:                  csr_prdata = '0;
      endcase
   end

   // Handshake stages: advance whenever the output register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || !out_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)   in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance)         out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   pcsc_scan #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .process    (advance),
      .opcode     (in_opcode_ff),
      .line_levels(in_levels_ff),
      .stat_index (in_index_ff),
      .cfg        (cfg_ff),
      .status     (status),
      .scan_event (scan_event),
      .read_value (scan_read)
   );

   pcsc_stats #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_stats (
      .clock     (clock),
      .reset     (reset),
      .scan_event(scan_event),
      .stat_index(in_index_ff),
      .read_value(stats_read)
   );

   assign read_value = (in_opcode_ff == pcsc_pkg::OP_READ) ? (scan_read | stats_read) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reference_settle <= pcsc_pkg::REF_SETTLE_RESET;
         cfg_ff.test_settle      <= pcsc_pkg::TST_SETTLE_RESET;
         cfg_ff.ref_scan_total   <= pcsc_pkg::REF_SCANS_RESET;
         cfg_ff.test_scans       <= pcsc_pkg::TST_SCANS_RESET;
         cfg_ff.warmup_scans     <= pcsc_pkg::WARMUP_RESET;
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: hold the transaction and its result
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_opcode_ff <= req_tuser;
         in_levels_ff <= req_tdata[LINES-1:0];
         in_index_ff  <= req_tdata[LINES+5:LINES];
      end
      if (advance) begin
         out_status_ff <= status;
         out_read_ff   <= read_value;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_read_ff,
                        out_status_ff.start_refused,
                        out_status_ff.reference_valid,
                        out_status_ff.run_state,
                        out_status_ff.scan_map,
                        out_status_ff.scan_done,
                        out_status_ff.drive_line};

endmodule

// ===== sim/pcsc_status_monitor.sv =====
module pcsc_status_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // line_levels[6:0], stat_index[12:7], zero above
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // drive_line, scan_done, scan_map, run_state,
                                    // reference_valid, start_refused, read_value
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int unsigned fail_count = 0,
   output int unsigned waiting_results = 0,
   output int unsigned scans_seen = 0
);
   import pcsc_pkg::*;

   // Result word, last member in the lowest bits
   typedef struct packed {
      logic [2:0]            padding;
      logic [31:0]           read_value;
      logic                  start_refused;
      logic                  reference_valid;
      logic [1:0]            run_state;
      logic [PAIRS-1:0]      scan_map;
      logic                  scan_done;
      logic [DRIVE_BITS-1:0] drive_line;
   } status_word_type;

   status_word_type predicted_status[$];

   // Register copies
   logic [15:0] ref_settle, tst_settle, ref_scans;
   logic [19:0] tst_scans;
   logic [7:0]  warmup;

   // Scanner state
   logic [1:0]            phase;
   logic [DRIVE_BITS-1:0] drive;
   logic [15:0]           settle_left;
   logic [PAIRS-1:0]      partial, ref_map, first_dis_map, first_err_map;
   logic [19:0]           scan_no;
   logic                  ref_ok;
   logic [31:0]           disagree_cnt, first_dis_scan, first_err_scan;
   logic [31:0]           summary[SUM_COUNT];
   logic [31:0]           fp_hits[PAIRS];
   logic [31:0]           fn_hits[PAIRS];

   function automatic logic [31:0] bump(input logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   function automatic void reload_settle();
      settle_left = (phase == PHASE_REFERENCE) ? ref_settle : tst_settle;
   endfunction

   function automatic void begin_run(input logic [1:0] p);
      phase   = p;
      drive   = '0;
      partial = '0;
      scan_no = '0;
      reload_settle();
   endfunction

   function automatic void close_scan(input logic [PAIRS-1:0] map);
      logic [PAIRS-1:0] fp, fn;
      logic [19:0]      target;
      if (phase == PHASE_REFERENCE) begin
         if (scan_no == 0) begin
            ref_map = map;
         end else if (map != ref_map) begin
            disagree_cnt = bump(disagree_cnt);
            if (first_dis_scan == 0) begin
               first_dis_scan = 32'(scan_no) + 32'd1;
               first_dis_map  = map;
            end
         end
         scan_no = scan_no + 1'b1;
         target  = (ref_scans == 0) ? 20'd1 : 20'(ref_scans);
         if (scan_no >= target) begin
            ref_ok = (disagree_cnt == 0);
            phase  = PHASE_IDLE;
         end
      end else if (phase == PHASE_WARMUP) begin
         scan_no = scan_no + 1'b1;
         if (scan_no >= 20'(warmup)) begin
            phase   = PHASE_MEASURE;
            scan_no = '0;
         end
      end else begin
         scan_no = scan_no + 1'b1;
         summary[SUM_SCANS] = bump(summary[SUM_SCANS]);
         if (map != ref_map) begin
            fp = map & ~ref_map;
            fn = ref_map & ~map;
            summary[SUM_INCORRECT] = bump(summary[SUM_INCORRECT]);
            if (first_err_scan == 0) begin
               first_err_scan = 32'(scan_no);
               first_err_map  = map;
            end
            if (fp != 0) summary[SUM_FP] = bump(summary[SUM_FP]);
            if (fn != 0) summary[SUM_FN] = bump(summary[SUM_FN]);
            for (int k = 0; k < PAIRS; k++) begin
               if (fp[k]) fp_hits[k] = bump(fp_hits[k]);
               if (fn[k]) fn_hits[k] = bump(fn_hits[k]);
            end
         end
         target = (tst_scans == 0) ? 20'd1 : tst_scans;
         if (scan_no >= target) phase = PHASE_IDLE;
      end
   endfunction

   function automatic void take_tick(input logic [LINES-1:0] levels, output logic done,
                                     output logic [PAIRS-1:0] map);
      int d, base;
      done = 1'b0;
      map  = '0;
      if (phase == PHASE_IDLE) return;
      if (phase == PHASE_MEASURE) summary[SUM_ELAPSED] = bump(summary[SUM_ELAPSED]);
      if (settle_left != 0) begin
         settle_left = settle_left - 16'd1;
         return;
      end
      d = int'(drive);
      // pairs are numbered drive by drive, so the driven line's block starts here
      base = d * (LINES - 1) - d * (d - 1) / 2;
      for (int s = d + 1; s < LINES; s++) begin
         if (!levels[s]) partial[base + s - d - 1] = 1'b1;
      end
      if (d + 2 >= LINES) begin
         map     = partial;
         done    = 1'b1;
         partial = '0;
         drive   = '0;
         reload_settle();
         close_scan(map);
      end else begin
         drive = drive + 1'b1;
         reload_settle();
      end
   endfunction

   function automatic logic [31:0] stat_value(input logic [5:0] idx);
      case (idx)
         STAT_REF_MAP:        return 32'(ref_map);
         STAT_DISAGREE:       return disagree_cnt;
         STAT_FIRST_DIS_SCAN: return first_dis_scan;
         STAT_FIRST_DIS_MAP:  return 32'(first_dis_map);
         STAT_MEASURED:       return summary[SUM_SCANS];
         STAT_INCORRECT:      return summary[SUM_INCORRECT];
         STAT_FP_SCANS:       return summary[SUM_FP];
         STAT_FN_SCANS:       return summary[SUM_FN];
         STAT_FIRST_ERR_SCAN: return first_err_scan;
         STAT_FIRST_ERR_MAP:  return 32'(first_err_map);
         STAT_ELAPSED:        return summary[SUM_ELAPSED];
         STAT_SCANS_IN_RUN:   return 32'(scan_no);
         default: ;
      endcase
      if (idx >= STAT_FP_BASE && idx < STAT_FN_BASE) return fp_hits[idx - STAT_FP_BASE];
      if (idx >= STAT_FN_BASE && idx < STAT_END) return fn_hits[idx - STAT_FN_BASE];
      return '0;
   endfunction

   function automatic status_word_type step_scanner(input logic [1:0] op,
                                                    input logic [LINES-1:0] levels,
                                                    input logic [5:0] idx);
      status_word_type  r;
      logic             done;
      logic [PAIRS-1:0] map;
      r    = '0;
      done = 1'b0;
      map  = '0;
      case (op)
         OP_TICK: take_tick(levels, done, map);
         OP_START_REF: begin
            if (phase != PHASE_IDLE) begin
               r.start_refused = 1'b1;
            end else begin
               ref_ok         = 1'b0;
               disagree_cnt   = '0;
               first_dis_scan = '0;
               first_dis_map  = '0;
               begin_run(PHASE_REFERENCE);
            end
         end
         OP_START_TST: begin
            if (phase != PHASE_IDLE || !ref_ok) begin
               r.start_refused = 1'b1;
            end else begin
               foreach (summary[i]) summary[i] = '0;
               foreach (fp_hits[k]) begin
                  fp_hits[k] = '0;
                  fn_hits[k] = '0;
               end
               first_err_scan = '0;
               first_err_map  = '0;
               begin_run((warmup != 0) ? PHASE_WARMUP : PHASE_MEASURE);
            end
         end
         OP_READ: r.read_value = stat_value(idx);
         default: ;
      endcase
      r.drive_line      = (phase == PHASE_IDLE) ? IDLE_LINE : drive;
      r.scan_done       = done;
      r.scan_map        = map;
      r.run_state       = phase;
      r.reference_valid = ref_ok;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      status_word_type got, want;
      if (reset) begin
         ref_settle     = REF_SETTLE_RESET;
         tst_settle     = TST_SETTLE_RESET;
         ref_scans      = REF_SCANS_RESET;
         tst_scans      = TST_SCANS_RESET;
         warmup         = WARMUP_RESET;
         phase          = PHASE_IDLE;
         drive          = '0;
         settle_left    = '0;
         partial        = '0;
         scan_no        = '0;
         ref_map        = '0;
         ref_ok         = 1'b0;
         disagree_cnt   = '0;
         first_dis_scan = '0;
         first_dis_map  = '0;
         first_err_scan = '0;
         first_err_map  = '0;
         foreach (summary[i]) summary[i] = '0;
         foreach (fp_hits[k]) begin
            fp_hits[k] = '0;
            fn_hits[k] = '0;
         end
         predicted_status.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_REF_SETTLE: ref_settle = csr_pwdata[15:0];
               REG_TST_SETTLE: tst_settle = csr_pwdata[15:0];
               REG_REF_SCANS:  ref_scans  = csr_pwdata[15:0];
               REG_TST_SCANS:  tst_scans  = csr_pwdata[19:0];
               REG_WARMUP:     warmup     = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (predicted_status.size() == 0) begin
               $error("result transaction 0x%0h arrived with nothing outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = predicted_status.pop_front();
               if (want.scan_done) scans_seen++;
               check_field("drive_line", 32'(want.drive_line), 32'(got.drive_line));
               check_field("scan_done", 32'(want.scan_done), 32'(got.scan_done));
               check_field("scan_map", 32'(want.scan_map), 32'(got.scan_map));
               check_field("run_state", 32'(want.run_state), 32'(got.run_state));
               check_field("reference_valid", 32'(want.reference_valid),
                           32'(got.reference_valid));
               check_field("start_refused", 32'(want.start_refused), 32'(got.start_refused));
               check_field("read_value", want.read_value, got.read_value);
               check_field("padding", 32'(want.padding), 32'(got.padding));
            end
         end
         if (req_tvalid && req_tready) begin
            predicted_status.push_back(step_scanner(req_tuser, req_tdata[6:0],
                                                    req_tdata[12:7]));
         end
      end
      waiting_results = predicted_status.size();
   end

endmodule

// ===== sim/tb_pairwise_continuity_scan_checker_top.sv =====
module tb_pairwise_continuity_scan_checker_top;
   import pcsc_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int TAIL_ITEMS   = 150;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // line_levels[6:0], stat_index[12:7], zero above
   logic [1:0]  req_tuser   = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b1;
   logic [63:0] rsp_tdata;          // drive_line[2:0], scan_done[3], scan_map[24:4],
                                    // run_state[26:25], reference_valid[27],
                                    // start_refused[28], read_value[60:29], zero above
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned fail_count, waiting_results, scans_seen;
   bit          gaps_on     = 1'b0;
   int          gap_stop    = 1 << 30;
   int          stall_left  = 0;
   int          cycle_count = 0;
   int          item_count  = 0;
   int          op_count[4] = '{default: 0};

   pairwise_continuity_scan_checker_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pcsc_status_monitor monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .waiting_results (waiting_results),
      .scans_seen      (scans_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stall the result side in bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT,
                waiting_results);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Unused level and index fields carry random bits so those input bits toggle
   task automatic send_item(input logic [1:0] op, input logic [LINES-1:0] levels,
                            input logic [5:0] idx);
      int gap;
      // drop idling for the closing stretch of the run
      if (item_count >= gap_stop) gaps_on = 1'b0;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000,
                     (op == OP_READ) ? idx : 6'($urandom_range(0, 63)),
                     (op == OP_TICK) ? levels : LINES'($urandom_range(0, 127))};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
      op_count[op]++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (waiting_results != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [LINES-1:0] sampled_levels(input logic [LINES-1:0] pattern,
                                                       input int noise);
      if (noise != 0 && $urandom_range(0, noise - 1) == 0)
         return LINES'($urandom_range(0, 127));
      return pattern;
   endfunction

   // Send exactly n ticks, with reads (and busy starts where the run is sure to be active)
   task automatic run_ticks(input int n, input logic [LINES-1:0] pattern, input int noise,
                            input bit busy_starts);
      int left;
      left = n;
      while (left > 0) begin
         case ($urandom_range(0, 19))
            0: send_item(OP_READ, '0, 6'($urandom_range(0, 63)));
            1: begin
               if (busy_starts)
                  send_item($urandom_range(0, 1) ? OP_START_REF : OP_START_TST, '0, '0);
            end
            default: begin
               send_item(OP_TICK, sampled_levels(pattern, noise), '0);
               left--;
            end
         endcase
      end
   endtask

   initial begin
      int               rs, ts, rn, tn, wu, random_start, campaigns;
      int               ref_noise, tst_noise;
      logic [LINES-1:0] pattern, tst_pattern;
      campaigns = 0;
      repeat (11) @(posedge clock);
      reset   <= 1'b0;
      gaps_on  = 1'b1;

      // Directed: reads after reset, idle tick, test start with no reference
      send_item(OP_READ, '0, STAT_REF_MAP);
      send_item(OP_READ, '0, 6'd63);
      send_item(OP_TICK, 7'h00, '0);
      send_item(OP_START_TST, '0, '0);
      // zero settle, zero scan counts act as one, zero warm-up measures at once
      write_reg(REG_REF_SETTLE, 32'd0);
      write_reg(REG_REF_SCANS, 32'd0);
      write_reg(REG_TST_SETTLE, 32'd0);
      write_reg(REG_TST_SCANS, 32'd0);
      write_reg(REG_WARMUP, 32'd0);
      send_item(OP_START_REF, '0, '0);
      send_item(OP_START_REF, '0, '0);
      send_item(OP_START_TST, '0, '0);
      repeat (LINES - 1) send_item(OP_TICK, 7'h00, '0);
      send_item(OP_START_TST, '0, '0);
      repeat (LINES - 1) send_item(OP_TICK, 7'h7F, '0);
      send_item(OP_READ, '0, STAT_FN_BASE);
      send_item(OP_READ, '0, STAT_END - 6'd1);
      send_item(OP_READ, '0, STAT_INCORRECT);
      send_item(OP_READ, '0, STAT_ELAPSED);
      send_item(OP_TICK, 7'h7F, '0);

      // Largest counts, cut short by writes while the run is under way
      pattern = 7'b0110101;
      write_reg(REG_REF_SCANS, 32'hFFFF);
      send_item(OP_START_REF, '0, '0);
      run_ticks(2 * (LINES - 1), pattern, 0, 1'b1);
      write_reg(REG_TST_SETTLE, 32'hFFFF);
      write_reg(REG_REF_SCANS, 32'd2);
      run_ticks(LINES - 1, pattern, 0, 1'b1);
      write_reg(REG_TST_SETTLE, 32'd0);
      write_reg(REG_WARMUP, 32'hFF);
      write_reg(REG_TST_SCANS, 32'hFFFFF);
      send_item(OP_START_TST, '0, '0);
      run_ticks(3 * (LINES - 1), pattern, 0, 1'b0);
      write_reg(REG_REF_SETTLE, 32'hFFFF);
      write_reg(REG_WARMUP, 32'd2);
      run_ticks(5 * (LINES - 1), pattern, 3, 1'b0);
      write_reg(REG_TST_SCANS, 32'd2);
      run_ticks(LINES - 1, ~pattern, 0, 1'b0);
      repeat (12) send_item(OP_READ, '0, 6'($urandom_range(0, 63)));

      // Random campaigns: a reference run then a test run with fresh small settings
      random_start = item_count;
      gap_stop     = random_start + RANDOM_ITEMS - TAIL_ITEMS;
      while (item_count - random_start < RANDOM_ITEMS) begin
         gaps_on = (item_count - random_start < RANDOM_ITEMS - TAIL_ITEMS) &&
                   ($urandom_range(0, 3) != 0);
         rs = $urandom_range(0, 3);
         ts = $urandom_range(0, 3);
         rn = $urandom_range(0, 4);
         tn = $urandom_range(0, 6);
         wu = $urandom_range(0, 3);
         write_reg(REG_REF_SETTLE, 32'(rs));
         write_reg(REG_TST_SETTLE, 32'(ts));
         write_reg(REG_REF_SCANS, 32'(rn));
         write_reg(REG_TST_SCANS, 32'(tn));
         write_reg(REG_WARMUP, 32'(wu));
         pattern     = LINES'($urandom_range(0, 127));
         tst_pattern = ($urandom_range(0, 3) == 0) ? LINES'($urandom_range(0, 127)) : pattern;
         ref_noise   = ($urandom_range(0, 4) == 0) ? 6 : 0;
         tst_noise   = $urandom_range(0, 1) ? $urandom_range(3, 12) : 0;
         send_item(OP_START_REF, '0, '0);
         run_ticks((rn == 0 ? 1 : rn) * (LINES - 1) * (rs + 1), pattern, ref_noise, 1'b1);
         repeat ($urandom_range(1, 3)) send_item(OP_READ, '0, 6'($urandom_range(0, 63)));
         // refused when the reference disagreed; the ticks then find the block idle
         send_item(OP_START_TST, '0, '0);
         run_ticks((wu + (tn == 0 ? 1 : tn)) * (LINES - 1) * (ts + 1), tst_pattern,
                   tst_noise, 1'b0);
         repeat ($urandom_range(2, 6)) send_item(OP_READ, '0, 6'($urandom_range(0, 63)));
         campaigns++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d transactions: %0d ticks, %0d reference and %0d test starts, %0d reads",
               item_count, op_count[OP_TICK], op_count[OP_START_REF], op_count[OP_START_TST],
               op_count[OP_READ]);
      $display("Ran %0d random campaigns; %0d completed scans compared", campaigns, scans_seen);
      if (fail_count == 0 && waiting_results == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pcsc_pkg.sv
rtl/pcsc_scan.sv
rtl/pcsc_stats.sv
rtl/pairwise_continuity_scan_checker_top.sv
sim/pcsc_status_monitor.sv
sim/tb_pairwise_continuity_scan_checker_top.sv
